// ===== src/assert_macros.svh =====
// Assertion macros shared by the button mapper RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define GPRBM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define GPRBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gprbm_pkg.sv =====
// Shared types and constants for the gamepad report button mapper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gprbm_pkg;

  localparam int BTN_W       = 16;
  localparam int TABLE_DEPTH = 16;
  localparam int ID_W        = 4;
  localparam int OFF_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  localparam logic ANS_SUMMARY = 1'b0;
  localparam logic ANS_CLICK   = 1'b1;

  // Table update command.
  typedef struct packed {
    logic              wr;
    logic              clr;
    logic [ID_W-1:0]   id;
    logic [OFF_W-1:0]  offset;
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] value;
  } tbl_cmd_t;

  // One item leaving the input register.
  typedef struct packed {
    logic              fire;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } step_t;

endpackage

`default_nettype wire

// ===== src/gprbm_table.sv =====
// Button table (offset, mask, match value per button) and parallel byte match.
// Depends on gprbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprbm_table #(
  parameter int NUM_ENTRIES = 16,
  parameter int POS_W       = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire gprbm_pkg::tbl_cmd_t             cmd,
  input  wire logic [gprbm_pkg::BYTE_W-1:0]    data_byte,
  input  wire logic [POS_W-1:0]                position,
  input  wire logic                            pos_live,
  output logic      [gprbm_pkg::BTN_W-1:0]     match
);

  localparam int CMP_W = (POS_W > gprbm_pkg::OFF_W) ? POS_W : gprbm_pkg::OFF_W;

  logic [CMP_W-1:0] pos_cmp;
  assign pos_cmp = CMP_W'(position);

  for (genvar i = 0; i < gprbm_pkg::BTN_W; i++) begin : g_entry
    if (i < NUM_ENTRIES) begin : g_used
      logic [gprbm_pkg::OFF_W-1:0]  offset;
      logic [gprbm_pkg::BYTE_W-1:0] mask;
      logic [gprbm_pkg::BYTE_W-1:0] value;
      logic                         sel;

      assign sel = cmd.wr && (cmd.id == gprbm_pkg::ID_W'(i));

      always_ff @(posedge clk) begin
        if (rst) begin
          mask <= '0;
        end else if (sel) begin
          mask <= cmd.mask;
        end else if (cmd.clr) begin
          mask <= '0;
        end
      end

      // offset and value only matter once a write has set a mask
      always_ff @(posedge clk) begin
        if (sel) begin
          offset <= cmd.offset;
          value  <= cmd.value;
        end
      end

      assign match[i] = pos_live && (mask != '0)
                        && (CMP_W'(offset) == pos_cmp)
                        && ((data_byte & mask) == value);
    end else begin : g_none
      assign match[i] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/gprbm_track.sv =====
// Report byte position, pressed vector build-up, previous state and clicks.
// Depends on gprbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gprbm_track #(
  parameter int REPORT_BYTES = 64,
  parameter int POS_W        = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire gprbm_pkg::step_t                step,
  input  wire logic [gprbm_pkg::BTN_W-1:0]     match,
  output logic      [POS_W-1:0]                position,
  output logic                                 pos_live,
  output logic                                 res_valid,
  output logic                                 res_kind,
  output logic      [gprbm_pkg::BTN_W-1:0]     res_pressed,
  output logic      [gprbm_pkg::BTN_W-1:0]     res_clicks,
  output logic                                 res_hit
);

  logic [gprbm_pkg::BTN_W-1:0] building;
  logic [gprbm_pkg::BTN_W-1:0] prev;
  logic [gprbm_pkg::BTN_W-1:0] pending;

  logic [POS_W-1:0]            position_next;
  logic [gprbm_pkg::BTN_W-1:0] building_next;
  logic [gprbm_pkg::BTN_W-1:0] prev_next;
  logic [gprbm_pkg::BTN_W-1:0] pending_next;

  logic [gprbm_pkg::BTN_W-1:0] built;
  logic [gprbm_pkg::BTN_W-1:0] pend_rep;
  logic [gprbm_pkg::BTN_W-1:0] pend_qry;
  logic                        hit;
  logic                        is_byte;
  logic                        is_query;
  logic                        is_summary;

  assign pos_live   = ({1'b0, position} < (POS_W + 1)'(REPORT_BYTES));
  assign built      = building | match;
  assign pend_rep   = (built != prev) ? (built & ~prev) : pending;
  assign hit        = pending[step.id];
  assign pend_qry   = pending & ~(gprbm_pkg::BTN_W'(1) << step.id);
  assign is_byte    = (step.kind == gprbm_pkg::KIND_BYTE);
  assign is_query   = (step.kind == gprbm_pkg::KIND_QUERY);
  assign is_summary = is_byte && step.last;

  assign res_valid   = is_summary || is_query;
  assign res_kind    = is_query ? gprbm_pkg::ANS_CLICK : gprbm_pkg::ANS_SUMMARY;
  assign res_pressed = is_query ? prev : built;
  assign res_clicks  = is_query ? pend_qry : pend_rep;
  assign res_hit     = is_query && hit;

  always_comb begin
    position_next = position;
    building_next = building;
    prev_next     = prev;
    pending_next  = pending;
    if (step.fire) begin
      case (step.kind)
        gprbm_pkg::KIND_BYTE: begin
          if (step.last) begin
            position_next = '0;
            building_next = '0;
            prev_next     = built;
            pending_next  = pend_rep;
          end else begin
            building_next = built;
            if (pos_live) begin
              position_next = POS_W'(position + 1'b1);
            end
          end
        end
        gprbm_pkg::KIND_QUERY: begin
          pending_next = pend_qry;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      building <= '0;
      prev     <= '0;
      pending  <= '0;
    end else begin
      position <= position_next;
      building <= building_next;
      prev     <= prev_next;
      pending  <= pending_next;
    end
  end

  `GPRBM_ASSERT(a_pend_in_prev, clk, rst, ((pending & ~prev) == '0), "click without press")
  `GPRBM_ASSERT(a_pos_bound, clk, rst, ({1'b0, position} <= (POS_W + 1)'(REPORT_BYTES)), "position overrun")
  `GPRBM_ASSERT(a_report_end, clk, rst, (step.fire && is_summary |=> (position == '0) && (building == '0)), "report state not cleared")

endmodule

`default_nettype wire

// ===== src/gamepad_report_button_mapper.sv =====
// Top level of the gamepad report button mapper: input register, table,
// report tracker and result register. Depends on gprbm_pkg, gprbm_table,
// gprbm_track and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Turns a stream of gamepad report bytes into a pressed-button vector. Each
// transfer on the input carries one command (kind): table write, report
// byte, click query or clear-all-masks. Report bytes are matched against
// every table entry at once, so the block takes one item per clock while intake is not stalled. A
// result passes from the input register through short match logic into the result
// register, from which it leaves when out_ready is high.
// Items that give no result keep flowing while a finished result waits on
// the output; intake only stalls when the item in the input register has a
// result and the result register is full and not being read.
// The last byte of a report yields a summary (answer_kind 0) with the
// pressed vector and the pending clicks; a query yields answer_kind 1 with
// the queried click bit, which is then cleared.
// Table writes, clears and non-final bytes give no result. Buttons whose
// byte lies past the report end, or past REPORT_BYTES, count as released.
// Only the first min(NUM_BUTTONS, 16) buttons exist; writes to others are
// dropped and queries of them answer with no hit.
module gamepad_report_button_mapper #(
  parameter int NUM_BUTTONS  = 16,
  parameter int REPORT_BYTES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [gprbm_pkg::KIND_W-1:0]        kind,
  input  wire logic [gprbm_pkg::ID_W-1:0]          button_num,
  input  wire logic [gprbm_pkg::OFF_W-1:0]         byte_offset,
  input  wire logic [gprbm_pkg::BYTE_W-1:0]        bit_mask,
  input  wire logic [gprbm_pkg::BYTE_W-1:0]        match_value,
  input  wire logic [gprbm_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                                last_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     answer_kind,
  output logic      [gprbm_pkg::BTN_W-1:0]         pressed_now,
  output logic      [gprbm_pkg::BTN_W-1:0]         click_vector,
  output logic                                     click_hit
);

  localparam int NUM_ENTRIES = (NUM_BUTTONS > gprbm_pkg::TABLE_DEPTH)
                               ? gprbm_pkg::TABLE_DEPTH : NUM_BUTTONS;
  localparam int POS_W = $clog2(REPORT_BYTES + 1);

  // Input register
  logic                           s1_valid;
  logic [gprbm_pkg::KIND_W-1:0]   s1_kind;
  logic [gprbm_pkg::ID_W-1:0]     s1_id;
  logic [gprbm_pkg::OFF_W-1:0]    s1_offset;
  logic [gprbm_pkg::BYTE_W-1:0]   s1_mask;
  logic [gprbm_pkg::BYTE_W-1:0]   s1_value;
  logic [gprbm_pkg::BYTE_W-1:0]   s1_data;
  logic                           s1_last;

  logic                           adv;
  gprbm_pkg::tbl_cmd_t            cmd;
  gprbm_pkg::step_t               step;
  logic [gprbm_pkg::BTN_W-1:0]    match;
  logic [POS_W-1:0]               position;
  logic                           pos_live;
  logic                           res_valid;
  logic                           res_kind;
  logic [gprbm_pkg::BTN_W-1:0]    res_pressed;
  logic [gprbm_pkg::BTN_W-1:0]    res_clicks;
  logic                           res_hit;

  // An item leaves the input register unless it has a result and the
  // result register is full and stalled.
  assign adv      = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind   <= kind;
      s1_id     <= button_num;
      s1_offset <= byte_offset;
      s1_mask   <= bit_mask;
      s1_value  <= match_value;
      s1_data   <= data_byte;
      s1_last   <= last_byte;
    end
  end

  always_comb begin
    cmd.wr     = adv && (s1_kind == gprbm_pkg::KIND_WRITE);
    cmd.clr    = adv && (s1_kind == gprbm_pkg::KIND_CLEAR);
    cmd.id     = s1_id;
    cmd.offset = s1_offset;
    cmd.mask   = s1_mask;
    cmd.value  = s1_value;
    step.fire  = adv;
    step.kind  = s1_kind;
    step.id    = s1_id;
    step.last  = s1_last;
  end

  gprbm_table #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .POS_W       (POS_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s1_data),
    .position  (position),
    .pos_live  (pos_live),
    .match     (match)
  );

  gprbm_track #(
    .REPORT_BYTES (REPORT_BYTES),
    .POS_W        (POS_W)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .match       (match),
    .position    (position),
    .pos_live    (pos_live),
    .res_valid   (res_valid),
    .res_kind    (res_kind),
    .res_pressed (res_pressed),
    .res_clicks  (res_clicks),
    .res_hit     (res_hit)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      answer_kind  <= res_kind;
      pressed_now  <= res_pressed;
      click_vector <= res_clicks;
      click_hit    <= res_hit;
    end
  end

  `GPRBM_ASSERT(a_result_lands, clk, rst, (adv && res_valid |=> out_valid), "result dropped")
  `GPRBM_ASSERT(a_no_overwrite, clk, rst, (out_valid && !out_ready |-> !(adv && res_valid)), "result overwritten")
  `GPRBM_ASSERT_ALWAYS(a_reset_idle, clk, (rst |=> !s1_valid && !out_valid), "busy after reset")

endmodule

`default_nettype wire
